/* design/utf8_to_utf16_or_utf32_decoder_assert.svh */
// Assertion macros for the UTF-8 decoder checker.
`ifndef UTF8_TO_UTF16_OR_UTF32_DECODER_ASSERT_SVH
`define UTF8_TO_UTF16_OR_UTF32_DECODER_ASSERT_SVH

// Same-cycle implication, clocked on clk, off during reset.
`define UTFD_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, clocked on clk, off during reset.
`define UTFD_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

/* design/utfd_pkg.sv */
package utfd_pkg;

	localparam int CU_W = 21;

	// result status codes
	localparam logic [1:0] ST_OK   = 2'd0;
	localparam logic [1:0] ST_ERR  = 2'd1;
	localparam logic [1:0] ST_PART = 2'd2;

	localparam logic [7:0] LEAD_LIMIT = 8'hF5;
	localparam logic [7:0] KEEP2      = 8'h1F;
	localparam logic [7:0] KEEP3      = 8'h0F;
	localparam logic [7:0] KEEP4      = 8'h07;

	localparam logic [CU_W-1:0] SUPP_BASE = 21'h010000;
	localparam logic [CU_W-1:0] CP_MAX    = 21'h10FFFF;
	localparam logic [15:0]     SURR_HI   = 16'hD800;
	localparam logic [15:0]     SURR_LO   = 16'hDC00;

	typedef struct packed {
		logic [CU_W-1:0] code_unit;
		logic [1:0]      status;
		logic            last;
	} result_t;

	// what one decoded byte hands to the result buffer
	typedef struct packed {
		result_t    r0;
		result_t    r1;
		logic [1:0] count;
	} dec_out_t;

endpackage

/* design/utfd_decode.sv */
module utfd_decode (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              fire,
	input  logic [7:0]        byte_s1,
	input  logic              eos_s1,
	input  logic              output_form,
	output utfd_pkg::dec_out_t dec
);
	import utfd_pkg::*;

	logic [1:0]      pending_q;
	logic [CU_W-1:0] partial_q;
	logic [1:0]      pending_d;
	logic [CU_W-1:0] partial_d;

	logic            cont;
	logic [CU_W-1:0] cp;
	logic            emit;
	logic [19:0]     off;
	logic [CU_W-1:0] cp_off;

	assign cont   = (byte_s1[7:6] == 2'b10);

	always_comb begin
		pending_d = pending_q;
		partial_d = partial_q;
		cp        = {13'd0, byte_s1};
		emit      = 1'b0;
		dec       = '0;

		if (pending_q == 2'd0) begin
			if (cont || byte_s1 >= LEAD_LIMIT) begin
				dec.r0.status = ST_ERR;
				dec.count     = 2'd1;
			end else if (!byte_s1[7]) begin
				emit = 1'b1;
			end else if (byte_s1[7:5] == 3'b110) begin
				pending_d = 2'd1;
				partial_d = {13'd0, byte_s1 & KEEP2};
			end else if (byte_s1[7:4] == 4'b1110) begin
				pending_d = 2'd2;
				partial_d = {13'd0, byte_s1 & KEEP3};
			end else if (byte_s1[7:3] == 5'b11110) begin
				pending_d = 2'd3;
				partial_d = {13'd0, byte_s1 & KEEP4};
			end else begin
				dec.r0.status = ST_ERR;
				dec.count     = 2'd1;
			end
		end else if (cont) begin
			cp        = {partial_q[CU_W-7:0], byte_s1[5:0]};
			pending_d = pending_q - 2'd1;
			partial_d = cp;
			if (pending_q == 2'd1) begin
				emit      = 1'b1;
				partial_d = '0;
			end
		end else begin
			dec.r0.status = ST_ERR;
			dec.count     = 2'd1;
			pending_d     = 2'd0;
			partial_d     = '0;
		end

		cp_off = cp - SUPP_BASE;
		off    = cp_off[19:0];

		if (emit) begin
			if (!output_form || cp < SUPP_BASE) begin
				dec.r0.code_unit = cp;
				dec.count        = 2'd1;
			end else if (cp > CP_MAX) begin
				dec.r0.status = ST_ERR;
				dec.count     = 2'd1;
			end else begin
				dec.r0.code_unit = {5'd0, SURR_HI | {6'd0, off[19:10]}};
				dec.r1.code_unit = {5'd0, SURR_LO | {6'd0, off[9:0]}};
				dec.count        = 2'd2;
			end
		end

		// stream ended inside a sequence: nothing else was emitted this byte
		if (eos_s1 && pending_d != 2'd0) begin
			dec.r0.status = ST_PART;
			dec.count     = 2'd1;
			pending_d     = 2'd0;
			partial_d     = '0;
		end

		dec.r0.last = (dec.count == 2'd1);
		dec.r1.last = (dec.count == 2'd2);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pending_q <= 2'd0;
			partial_q <= '0;
		end else if (fire) begin
			pending_q <= pending_d;
			partial_q <= partial_d;
		end
	end

endmodule

/* design/utfd_outbuf.sv */
module utfd_outbuf (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               load,
	input  utfd_pkg::dec_out_t dec,
	input  logic               out_ready,
	output logic               free,
	output logic               out_valid,
	output utfd_pkg::result_t  head
);
	import utfd_pkg::*;

	logic [1:0] cnt_q;
	result_t    head_q;
	result_t    second_q;

	// buffer is empty or drains to empty this cycle
	assign free      = (cnt_q == 2'd0) || (cnt_q == 2'd1 && out_ready);
	assign out_valid = (cnt_q != 2'd0);
	assign head      = head_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= 2'd0;
		end else if (load) begin
			cnt_q <= dec.count;
		end else if (out_valid && out_ready) begin
			cnt_q <= cnt_q - 2'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			head_q   <= dec.r0;
			second_q <= dec.r1;
		end else if (cnt_q == 2'd2 && out_ready) begin
			head_q <= second_q;
		end
	end

endmodule

/* design/utf8_to_utf16_or_utf32_decoder.sv */
// UTF-8 to UTF-32 / UTF-16 decoder. Takes one byte per cycle on the input channel while
// in_ready is high and gives one result per cycle on the output channel while out_ready is
// high. A byte that completes a code point from 0x10000 to 0x10FFFF in UTF-16 form
// (cfg_write_data = 1) yields a surrogate pair, which fills the two-entry result buffer and
// keeps the next byte in the input register until the pair drains. A byte's results pass
// through the input register, then are decoded into the result buffer. Errors (status 1)
// and a stream that ends mid-sequence (status 2) give code_unit zero and return the
// decoder to idle.
// Write the output form only while no transaction is in flight.
module utf8_to_utf16_or_utf32_decoder (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [7:0]  byte_in,
	input  logic        end_of_stream,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [20:0] code_unit,
	output logic [1:0]  status,
	output logic        last_of_run,
	input  logic        cfg_write_en,
	input  logic        cfg_write_data
);
	import utfd_pkg::*;

	logic       output_form_q;
	logic       valid_s1;
	logic [7:0] byte_s1;
	logic       eos_s1;
	logic       free;
	logic       advance;
	dec_out_t   dec;
	result_t    head;

	assign advance  = valid_s1 && free;
	assign in_ready = !valid_s1 || free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			output_form_q <= 1'b0;
		end else if (cfg_write_en) begin
			output_form_q <= cfg_write_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_valid && in_ready) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			byte_s1 <= byte_in;
			eos_s1  <= end_of_stream;
		end
	end

	utfd_decode u_decode (
		.clk         (clk),
		.arst_n      (arst_n),
		.fire        (advance),
		.byte_s1     (byte_s1),
		.eos_s1      (eos_s1),
		.output_form (output_form_q),
		.dec         (dec)
	);

	utfd_outbuf u_outbuf (
		.clk       (clk),
		.arst_n    (arst_n),
		.load      (advance),
		.dec       (dec),
		.out_ready (out_ready),
		.free      (free),
		.out_valid (out_valid),
		.head      (head)
	);

	assign code_unit   = head.code_unit;
	assign status      = head.status;
	assign last_of_run = head.last;

endmodule

/* design/utfd_checker.sv */
`include "utf8_to_utf16_or_utf32_decoder_assert.svh"

module utfd_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        out_valid,
	input logic        out_ready,
	input logic [20:0] code_unit,
	input logic [1:0]  status,
	input logic        last_of_run
);
	import utfd_pkg::*;

	`UTFD_ASSERT_NOW(a_err_zero, out_valid && status != ST_OK, code_unit == '0,
		"error or partial result with nonzero code unit")
	`UTFD_ASSERT_NOW(a_status_code, out_valid,
		status == ST_OK || status == ST_ERR || status == ST_PART, "undefined status code")
	`UTFD_ASSERT_NOW(a_unit_range, out_valid, code_unit <= 21'h13FFFF,
		"code unit beyond the four-byte range")
	// the second unit of a pair follows at once
	`UTFD_ASSERT_NEXT(a_pair_follows, out_valid && out_ready && !last_of_run, out_valid,
		"result run cut short")
	`UTFD_ASSERT_NEXT(a_out_hold, out_valid && !out_ready,
		out_valid && $stable(code_unit) && $stable(status) && $stable(last_of_run),
		"stalled result changed")

endmodule

bind utf8_to_utf16_or_utf32_decoder utfd_checker u_utfd_checker (.*);
